@@ rtl/core/sacd_pkg.sv @@
// ----------------------------------------------------------------------------
// sacd_pkg
// Shared constants and types for the set-associative cache tag directory:
// default geometry, replacement policy codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package sacd_pkg;

  // Default geometry
  localparam int NUM_SETS_DEF   = 64;
  localparam int NUM_WAYS_DEF   = 4;
  localparam int LINE_BYTES_DEF = 16;
  localparam int STAMP_BITS_DEF = 32;

  // Address and data widths
  localparam int ADDR_W = 32;
  localparam int CNT_W  = 32;
  localparam int LFSR_W = 16;
  localparam int WAY_OUT_W = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Random victim generator
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // Replacement policy codes (the unused code behaves as LRU)
  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_LRU    = 2'd2;

  // Register map: register index taken from the word address
  localparam logic REG_REPLACE_POLICY = 1'b0;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

@@ rtl/core/sacd_lookup.sv @@
// ----------------------------------------------------------------------------
// sacd_lookup
// Compares one set's ways against a tag and picks the way to use: the hit
// way, else the first invalid way, else the random or oldest-stamp victim.
// ----------------------------------------------------------------------------
module sacd_lookup #(
  parameter int NUM_WAYS   = sacd_pkg::NUM_WAYS_DEF,
  parameter int TAG_W      = 24,
  parameter int STAMP_BITS = sacd_pkg::STAMP_BITS_DEF,
  parameter int WAY_W      = 2
) (
  input  logic [NUM_WAYS-1:0][TAG_W:0]        tag_row,
  input  logic [NUM_WAYS-1:0][STAMP_BITS-1:0] stamp_row,
  input  logic [TAG_W-1:0]                    tag,
  input  logic [1:0]                          policy,
  input  logic [WAY_W-1:0]                    rnd_way,
  output logic                                hit,
  output logic [WAY_W-1:0]                    way,
  output logic                                evicted
);

  localparam int P2 = 1 << WAY_W;

  logic             hit_c;
  logic [WAY_W-1:0] hit_way;
  logic             free;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] min_way;

  // Scan ways; the lowest matching or invalid way wins
  always_comb begin
    hit_c    = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (tag_row[w][TAG_W] && (tag_row[w][TAG_W-1:0] == tag)) begin
        hit_c   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!tag_row[w][TAG_W]) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // Find the smallest stamp with a pairwise tree; ties keep the lower way
  always_comb begin
    logic [STAMP_BITS-1:0] ts [P2];
    logic [WAY_W-1:0]      ti [P2];
    for (int i = 0; i < P2; i++) begin
      ts[i] = '1;
      if (i < NUM_WAYS) begin
        ts[i] = stamp_row[i];
      end
      ti[i] = WAY_W'(i);
    end
    for (int l = P2 >> 1; l >= 1; l = l >> 1) begin
      for (int i = 0; i < l; i++) begin
        if (ts[2*i+1] < ts[2*i]) begin
          ts[i] = ts[2*i+1];
          ti[i] = ti[2*i+1];
        end else begin
          ts[i] = ts[2*i];
          ti[i] = ti[2*i];
        end
      end
    end
    min_way = ti[0];
  end

  // Select the way to report and fill
  always_comb begin
    hit     = hit_c;
    evicted = !hit_c && !free;
    if (hit_c) begin
      way = hit_way;
    end else if (free) begin
      way = free_way;
    end else if (policy == sacd_pkg::POL_RANDOM) begin
      way = rnd_way;
    end else begin
      way = min_way;
    end
  end

endmodule

@@ rtl/core/set_assoc_cache_tag_directory.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_directory
// Tag directory of a set-associative cache with random, FIFO or LRU victim
// choice, saturating hit and miss counters and an APB configuration port.
// ----------------------------------------------------------------------------
// For each accepted address, the set's row is read from the tag and stamp
// memories into registers at the accept edge; then the row is compared, the
// victim is chosen and the updated row is written back while the result beat
// is loaded into the output register. The single-port row access of the two
// memories means no new address is taken until that write-back is done. A new
// address is taken while a finished result still waits on the output; the
// lookup holds only if the output register is still full and not being taken
// when it completes. After reset a clearing pass resets the valid bits, one
// set per cycle, and no address is accepted until it ends; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_directory #(
  parameter int NUM_SETS   = sacd_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS   = sacd_pkg::NUM_WAYS_DEF,
  parameter int LINE_BYTES = sacd_pkg::LINE_BYTES_DEF,
  parameter int STAMP_BITS = sacd_pkg::STAMP_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // address beats
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sacd_pkg::ADDR_W-1:0]      in_addr,
  // result beats
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic [sacd_pkg::WAY_OUT_W-1:0]   out_way,
  output logic                             out_evicted,
  output logic [sacd_pkg::CNT_W-1:0]       out_hit_total,
  output logic [sacd_pkg::CNT_W-1:0]       out_miss_total,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sacd_pkg::PADDR_W-1:0]     paddr,
  input  logic [sacd_pkg::PDATA_W-1:0]     pwdata,
  output logic [sacd_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam int OB     = $clog2(LINE_BYTES);
  localparam int IB     = $clog2(NUM_SETS);
  localparam int SET_W  = (IB > 0) ? IB : 1;
  localparam int TAG_SH = OB + IB;
  localparam int TAG_W  = sacd_pkg::ADDR_W - TAG_SH;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  localparam logic [SET_W:0]   SETS_L   = (SET_W + 1)'(NUM_SETS);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);
  localparam logic [SET_W-1:0] SET_MASK = (IB > 0) ? {SET_W{1'b1}} : '0;

  // reciprocal for the way modulo of the random value
  localparam int RND_SHIFT = sacd_pkg::LFSR_W + WAY_W;
  localparam logic [RND_SHIFT:0] RND_RECIP =
    (RND_SHIFT + 1)'(((1 << RND_SHIFT) + NUM_WAYS - 1) / NUM_WAYS);
  localparam int PROD_W = sacd_pkg::LFSR_W + RND_SHIFT + 1;

  typedef logic [NUM_WAYS-1:0][TAG_W:0]        tag_row_t;
  typedef logic [NUM_WAYS-1:0][STAMP_BITS-1:0] stamp_row_t;

  // memories: bit TAG_W of each way holds its valid flag
  tag_row_t   tag_mem   [NUM_SETS];
  stamp_row_t stamp_mem [NUM_SETS];

  sacd_pkg::state_t state_r, state_nxt;

  logic [1:0]                     policy_r;
  logic [SET_W-1:0]               clr_idx_r;
  logic [SET_W-1:0]               set_r;
  logic [TAG_W-1:0]               tag_r;
  tag_row_t                       tag_rd_r;
  stamp_row_t                     stamp_rd_r;
  logic [STAMP_BITS-1:0]          tick_r;
  logic [sacd_pkg::CNT_W-1:0]     hit_cnt_r;
  logic [sacd_pkg::CNT_W-1:0]     miss_cnt_r;
  logic [sacd_pkg::LFSR_W-1:0]    lfsr_r;
  logic [sacd_pkg::LFSR_W-1:0]    rnd_q_r;
  logic                           out_valid_r;
  logic                           out_hit_r;
  logic [sacd_pkg::WAY_OUT_W-1:0] out_way_r;
  logic                           out_evicted_r;
  logic [sacd_pkg::CNT_W-1:0]     out_hit_total_r;
  logic [sacd_pkg::CNT_W-1:0]     out_miss_total_r;

  logic                        accept;
  logic                        done;
  logic                        clr_we;
  logic [SET_W-1:0]            set_raw;
  logic [SET_W-1:0]            set_idx;
  logic [TAG_W-1:0]            tag_in;
  logic [sacd_pkg::LFSR_W-1:0] lfsr_step;
  logic [PROD_W-1:0]           rnd_prod;
  logic [sacd_pkg::LFSR_W-1:0] rnd_rem;
  logic [WAY_W-1:0]            rnd_way;
  logic                        lk_hit;
  logic [WAY_W-1:0]            lk_way;
  logic                        lk_evicted;
  logic                        stamp_on_hit;
  logic [STAMP_BITS-1:0]       tick_inc;
  tag_row_t                    tag_wr;
  stamp_row_t                  stamp_wr;

  // Split the address into set and tag; fold the set field into range
  always_comb begin
    set_raw = SET_W'(in_addr >> OB) & SET_MASK;
    if ({1'b0, set_raw} >= SETS_L) begin
      set_idx = set_raw - SETS_L[SET_W-1:0];
    end else begin
      set_idx = set_raw;
    end
    tag_in = TAG_W'(in_addr >> TAG_SH);
  end

  // Sequencer: clearing pass, idle, lookup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacd_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    done      = 1'b0;
    clr_we    = 1'b0;
    case (state_r)
      sacd_pkg::ST_CLEAR: begin
        clr_we = 1'b1;
        if (clr_idx_r == LAST_SET) begin
          state_nxt = sacd_pkg::ST_IDLE;
        end
      end
      sacd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = sacd_pkg::ST_LOOKUP;
        end
      end
      sacd_pkg::ST_LOOKUP: begin
        done = !out_valid_r || out_ready;
        if (done) begin
          state_nxt = sacd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sacd_pkg::ST_CLEAR;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  // Step the clearing pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (clr_we) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // Hold the accepted address fields for the lookup cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= set_idx;
      tag_r <= tag_in;
    end
  end

  // Random victim: one Galois step, then modulo by reciprocal multiply
  assign lfsr_step = {1'b0, lfsr_r[sacd_pkg::LFSR_W-1:1]}
                     ^ (lfsr_r[0] ? sacd_pkg::LFSR_TAPS : '0);
  assign rnd_prod  = PROD_W'(lfsr_step) * PROD_W'(RND_RECIP);

  always_ff @(posedge clk) begin
    rnd_q_r <= sacd_pkg::LFSR_W'(rnd_prod >> RND_SHIFT);
  end

  assign rnd_rem = lfsr_step - sacd_pkg::LFSR_W'(rnd_q_r * NUM_WAYS);
  assign rnd_way = WAY_W'(rnd_rem);

  // Compare the set and choose the way
  sacd_lookup #(
    .NUM_WAYS   (NUM_WAYS),
    .TAG_W      (TAG_W),
    .STAMP_BITS (STAMP_BITS),
    .WAY_W      (WAY_W)
  ) u_lookup (
    .tag_row   (tag_rd_r),
    .stamp_row (stamp_rd_r),
    .tag       (tag_r),
    .policy    (policy_r),
    .rnd_way   (rnd_way),
    .hit       (lk_hit),
    .way       (lk_way),
    .evicted   (lk_evicted)
  );

  // Build the rows to write back
  assign tick_inc     = tick_r + 1'b1;
  assign stamp_on_hit = (policy_r != sacd_pkg::POL_RANDOM) &&
                        (policy_r != sacd_pkg::POL_FIFO);

  always_comb begin
    tag_wr   = tag_rd_r;
    stamp_wr = stamp_rd_r;
    if (!lk_hit) begin
      tag_wr[lk_way] = {1'b1, tag_r};
    end
    if (!lk_hit || stamp_on_hit) begin
      stamp_wr[lk_way] = tick_inc;
    end
  end

  // Tag and valid memory: clear, write back, read on accept
  always_ff @(posedge clk) begin
    if (clr_we) begin
      tag_mem[clr_idx_r] <= '0;
    end else if (done) begin
      tag_mem[set_r] <= tag_wr;
    end
    if (accept) begin
      tag_rd_r <= tag_mem[set_idx];
    end
  end

  // Stamp memory: write back, read on accept
  always_ff @(posedge clk) begin
    if (done) begin
      stamp_mem[set_r] <= stamp_wr;
    end
    if (accept) begin
      stamp_rd_r <= stamp_mem[set_idx];
    end
  end

  // Advance tick and counters as each lookup completes, and the random state on each random-policy eviction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      lfsr_r     <= sacd_pkg::LFSR_SEED;
    end else if (done) begin
      tick_r <= tick_inc;
      if (lk_hit && (hit_cnt_r != '1)) begin
        hit_cnt_r <= hit_cnt_r + 1'b1;
      end
      if (!lk_hit && (miss_cnt_r != '1)) begin
        miss_cnt_r <= miss_cnt_r + 1'b1;
      end
      if (lk_evicted && (policy_r == sacd_pkg::POL_RANDOM)) begin
        lfsr_r <= lfsr_step;
      end
    end
  end

  // Output register: load on completion, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_hit_r        <= lk_hit;
      out_way_r        <= sacd_pkg::WAY_OUT_W'(lk_way);
      out_evicted_r    <= lk_evicted;
      out_hit_total_r  <= (lk_hit && (hit_cnt_r != '1)) ? hit_cnt_r + 1'b1 : hit_cnt_r;
      out_miss_total_r <= (!lk_hit && (miss_cnt_r != '1)) ? miss_cnt_r + 1'b1 : miss_cnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_way        = out_way_r;
  assign out_evicted    = out_evicted_r;
  assign out_hit_total  = out_hit_total_r;
  assign out_miss_total = out_miss_total_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= sacd_pkg::POL_LRU;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == sacd_pkg::REG_REPLACE_POLICY)) begin
      policy_r <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sacd_pkg::REG_REPLACE_POLICY) ?
                  sacd_pkg::PDATA_W'(policy_r) : '0;

endmodule
